>>> src/qts_pkg.sv
// Shared types, codes and the escape decode for the quoted token splitter.
// Depends on nothing; every other file imports it.
package qts_pkg;

  localparam logic       KIND_CHAR = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ESCAPE   = 2'd1;
  localparam logic [1:0] ERR_LINE_END = 2'd2;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_WS_LO  = 8'h09;
  localparam logic [7:0] CH_WS_HI  = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } qts_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_out;
    logic        run_last;
    logic [1:0]  error_code;
    logic [15:0] error_index;
    logic [7:0]  error_char;
  } qts_out_t;

  // Results of one byte: count, then up to two result beats in order.
  typedef struct packed {
    logic [1:0] n;
    qts_out_t   r0;
    qts_out_t   r1;
  } qts_pair_t;

  // Core status, watched by the top level.
  typedef struct packed {
    logic       in_token;
    logic [1:0] quote_mode;
    logic       escape_pending;
    logic [1:0] error_code;
  } qts_stat_t;

  // Bit 8 set when the escape letter is supported; low byte is the mapped char.
  function automatic logic [8:0] qts_escape(input logic [7:0] c);
    logic [8:0] r;
    r = {1'b0, c};
    case (c)
      CH_N:      r = {1'b1, 8'h0A};
      CH_T:      r = {1'b1, 8'h09};
      CH_R:      r = {1'b1, 8'h0D};
      CH_A:      r = {1'b1, 8'h07};
      CH_B:      r = {1'b1, 8'h08};
      CH_F:      r = {1'b1, 8'h0C};
      CH_V:      r = {1'b1, 8'h0B};
      CH_DQUOTE: r = {1'b1, CH_DQUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SQUOTE: r = {1'b1, CH_SQUOTE};
      default:   r = {1'b0, c};
    endcase
    return r;
  endfunction

endpackage

>>> src/qts_core.sv
// Tokenizer state and the per-byte decode that yields up to two result beats.
// Depends on qts_pkg.
module qts_core import qts_pkg::*; #(
  parameter longint unsigned MAX_LINE_BYTES = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  qts_in_t   beat,
  output qts_pair_t pair,
  output qts_stat_t stat
);

  localparam int unsigned POS_W = $clog2(MAX_LINE_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE_BYTES - 1);

  logic             in_token,  in_token_next;
  logic [1:0]       quote_mode, quote_mode_next;
  logic             escape_pending, escape_pending_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [1:0]       err_code, err_code_next;
  logic [15:0]      err_index, err_index_next;
  logic [7:0]       err_char, err_char_next;

  logic [POS_W-1:0] bs_pos;
  logic [POS_W+15:0] pos_ext, bs_ext;
  logic [8:0]       esc;
  logic [7:0]       c, q;
  logic             has0, kind0, has_end;
  logic [7:0]       char0;
  qts_out_t         r0, r1;

  always_comb begin
    c       = beat.char_in;
    esc     = qts_escape(c);
    bs_pos  = (byte_position == '0) ? POS_MAX : byte_position - POS_W'(1);
    pos_ext = {16'd0, byte_position};
    bs_ext  = {16'd0, bs_pos};
    q       = (quote_mode == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

    in_token_next       = in_token;
    quote_mode_next     = quote_mode;
    escape_pending_next = escape_pending;
    err_code_next       = err_code;
    err_index_next      = err_index;
    err_char_next       = err_char;
    has0                = 1'b0;
    kind0               = KIND_CHAR;
    char0               = c;

    if (escape_pending) begin
      escape_pending_next = 1'b0;
      has0  = 1'b1;
      char0 = esc[7:0];
      if (!esc[8] && err_code == ERR_NONE) begin
        err_code_next  = ERR_ESCAPE;
        err_index_next = bs_ext[15:0];
        err_char_next  = c;
      end
    end else if (quote_mode != QUOTE_NONE) begin
      if (c == q) begin
        quote_mode_next = QUOTE_NONE;
      end else if (c == CH_BSLASH) begin
        escape_pending_next = 1'b1;
      end else begin
        has0 = 1'b1;
      end
    end else if (c == CH_SPACE || (c >= CH_WS_LO && c <= CH_WS_HI)) begin
      if (in_token) begin
        has0  = 1'b1;
        kind0 = KIND_END;
        char0 = 8'd0;
      end
      in_token_next = 1'b0;
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      in_token_next   = 1'b1;
      quote_mode_next = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
    end else begin
      in_token_next = 1'b1;
      has0          = 1'b1;
    end

    // Backslash as the last byte inside quotes.
    if (beat.line_end && escape_pending_next && err_code_next == ERR_NONE) begin
      err_code_next  = ERR_LINE_END;
      err_index_next = pos_ext[15:0];
      err_char_next  = 8'd0;
    end
    has_end = beat.line_end && in_token_next;

    byte_position_next = (byte_position == POS_MAX) ? '0 : byte_position + POS_W'(1);

    r1.kind        = KIND_END;
    r1.char_out    = 8'd0;
    r1.run_last    = 1'b1;
    r1.error_code  = err_code_next;
    r1.error_index = err_index_next;
    r1.error_char  = err_char_next;

    r0             = r1;
    if (has0) begin
      r0.kind     = kind0;
      r0.char_out = char0;
      r0.run_last = !has_end;
    end

    pair.n  = {1'b0, has0} + {1'b0, has_end};
    pair.r0 = r0;
    pair.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && beat.line_end)) begin
      in_token       <= 1'b0;
      quote_mode     <= QUOTE_NONE;
      escape_pending <= 1'b0;
      byte_position  <= '0;
      err_code       <= ERR_NONE;
      err_index      <= 16'd0;
      err_char       <= 8'd0;
    end else if (advance) begin
      in_token       <= in_token_next;
      quote_mode     <= quote_mode_next;
      escape_pending <= escape_pending_next;
      byte_position  <= byte_position_next;
      err_code       <= err_code_next;
      err_index      <= err_index_next;
      err_char       <= err_char_next;
    end
  end

  assign stat.in_token       = in_token;
  assign stat.quote_mode     = quote_mode;
  assign stat.escape_pending = escape_pending;
  assign stat.error_code     = err_code;

endmodule

>>> src/qts_outbuf.sv
// Two-entry result register: loads a byte's result pair, drains one beat a cycle unless stalled.
// Depends on qts_pkg.
module qts_outbuf import qts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  qts_pair_t pair,
  output logic      ready,
  output logic      valid,
  input  logic      stall,
  output qts_out_t  head
);

  logic [1:0] cnt;
  qts_out_t   e0, e1;
  logic       take;

  assign take  = valid && !stall;
  assign valid = (cnt != 2'd0);
  assign ready = (cnt == 2'd0) || (cnt == 2'd1 && take);
  assign head  = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= pair.n;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Shift the second beat forward when the head is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      e0 <= pair.r0;
      e1 <= pair.r1;
    end else if (take) begin
      e0 <= e1;
    end
  end

endmodule

>>> src/quoted_token_splitter_top.sv
// Top level of the quoted token splitter: input register, tokenizer core, result buffer.
// Depends on qts_pkg, qts_core and qts_outbuf.
//
// Usage:
//   Byte channel (byte_valid, byte_stall, byte_beat): one raw byte of a command line
//   per beat, line_end set on the final byte of the line. A beat is taken at an edge
//   with byte_valid high and byte_stall low.
//   Token channel (tok_valid, tok_stall, tok_beat): token characters (kind 0) and
//   end-of-token marks (kind 1), each with the first error of the line so far.
//   run_last flags the last beat produced by one input byte; a byte may produce
//   zero, one or two beats.
//   Path: a taken byte is held in the input register and decoded there by the core;
//   its result pair is loaded into the result register, whose head drives tok_beat.
//   Throughput: one byte per cycle while each byte yields at most one beat and tok_stall
//   is low; after a byte that yields a character and an end mark, the next byte waits
//   until its second beat is taken; the two-entry register drains one beat per unstalled cycle.
//   Stall: while tok_stall is high the head beat holds; byte_stall rises once the
//   input register is full and the result register cannot take the next pair.
//   Reset: rst (synchronous) clears the tokenizer state and empties both registers.
//   All tokenizer state also clears after the byte that carries line_end.
module quoted_token_splitter_top import qts_pkg::*; #(
  parameter longint unsigned MAX_LINE_BYTES = 65536
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  qts_in_t  byte_beat,
  output logic     tok_valid,
  input  logic     tok_stall,
  output qts_out_t tok_beat
);

  logic      in_full;
  qts_in_t   in_q;
  logic      ob_ready;
  logic      advance;
  logic      accept;
  qts_pair_t pair;
  qts_stat_t stat;

  // Advance the held byte whenever the result register can take its pair.
  assign advance    = in_full && ob_ready;
  assign byte_stall = in_full && !ob_ready;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= byte_beat;
    end
  end

  qts_core #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .beat   (in_q),
    .pair   (pair),
    .stat   (stat)
  );

  qts_outbuf u_outbuf (
    .clk  (clk),
    .rst  (rst),
    .load (advance),
    .pair (pair),
    .ready(ob_ready),
    .valid(tok_valid),
    .stall(tok_stall),
    .head (tok_beat)
  );

  // Line end leaves the tokenizer cleared.
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && in_q.line_end) |=> (!stat.in_token && stat.quote_mode == QUOTE_NONE &&
                                    !stat.escape_pending && stat.error_code == ERR_NONE))
    else $error("tokenizer state not cleared after line end");

  // An escape can only be pending inside quotes.
  a_escape_in_quotes: assert property (@(posedge clk) disable iff (rst)
    stat.escape_pending |-> stat.quote_mode != QUOTE_NONE)
    else $error("escape pending outside quotes");

  // The first error of a line sticks until the line ends.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (stat.error_code != ERR_NONE && !(advance && in_q.line_end))
      |=> stat.error_code == $past(stat.error_code))
    else $error("first error overwritten within a line");

  // A held byte is never overwritten before it advances.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_q)))
    else $error("input register lost a byte");

endmodule
